// ===== hw/rtl/pwsr_pkg.sv =====
// ----------------------------------------------------------------------------
// pwsr_pkg
// Shared types and constants for the sorted azimuth range unit.
// ----------------------------------------------------------------------------
package pwsr_pkg;

    localparam int MAX_HITS = 256;
    localparam int IDX_W    = $clog2(MAX_HITS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int PHI_W    = 16;
    localparam int ID_W     = 16;
    localparam int WIN_W    = 17;
    // Keys are held one bit wider than the window so that offsets never wrap.
    localparam int KEY_W    = WIN_W + 1;

    localparam logic signed [KEY_W-1:0] PI_FX     = KEY_W'(32768);
    localparam logic signed [KEY_W-1:0] NEG_PI_FX = -KEY_W'(32768);
    localparam logic signed [KEY_W-1:0] TWO_PI_FX = KEY_W'(65536);

    typedef enum logic [1:0]
    {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [1:0]
    {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_IDX = 2'd2
    } status_t;

    // Request from the sequencer to the search unit.
    typedef struct packed
    {
        logic                    start;
        logic [CNT_W-1:0]        from;
        logic signed [KEY_W-1:0] key;
        logic                    strict;
    } srch_req_t;

    typedef struct packed
    {
        logic             done;
        logic [CNT_W-1:0] result;
    } srch_rsp_t;

endpackage

// ===== hw/rtl/pwsr_search.sv =====
// ----------------------------------------------------------------------------
// pwsr_search
// Binary search over the sorted angle store; each probe passes through an address state and a compare state.
// ----------------------------------------------------------------------------
module pwsr_search
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pwsr_pkg::srch_req_t                  req,
    input  logic [pwsr_pkg::CNT_W-1:0]           count,
    output logic [pwsr_pkg::IDX_W-1:0]           rd_addr,
    input  logic signed [pwsr_pkg::PHI_W-1:0]    rd_data,
    output pwsr_pkg::srch_rsp_t                  rsp
);

    typedef enum logic [1:0] {S_IDLE, S_ADDR, S_CMP} state_t;

    state_t                              state_reg, state_next;
    logic [pwsr_pkg::CNT_W-1:0]          lo_reg, lo_next, hi_reg, hi_next;
    logic signed [pwsr_pkg::KEY_W-1:0]   key_reg, key_next;
    logic                                strict_reg, strict_next;
    logic                                done_reg, done_next;
    logic [pwsr_pkg::CNT_W-1:0]          mid;
    logic signed [pwsr_pkg::KEY_W-1:0]   angle;
    logic                                past;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_addr = mid[pwsr_pkg::IDX_W-1:0];
    assign angle   = pwsr_pkg::KEY_W'(rd_data);
    assign past    = strict_reg ? (angle > key_reg) : (angle >= key_reg);
    assign rsp.done   = done_reg;
    assign rsp.result = lo_reg;

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        key_next    = key_reg;
        strict_next = strict_reg;
        done_next   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    lo_next     = req.from;
                    hi_next     = count;
                    key_next    = req.key;
                    strict_next = req.strict;
                    state_next  = S_ADDR;
                end
            end
            S_ADDR:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CMP:
            begin
                if (past)
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid + 1'b1;
                end
                state_next = S_ADDR;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            key_reg    <= '0;
            strict_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            key_reg    <= key_next;
            strict_reg <= strict_next;
        end
    end

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> lo_reg < hi_reg)
        else $error("search bounds crossed");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("search done while busy");
    a_hi_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> hi_reg <= count)
        else $error("search upper bound beyond count");

endmodule

// ===== hw/rtl/phi_window_sorted_range_unit.sv =====
// ----------------------------------------------------------------------------
// phi_window_sorted_range_unit
// Sorted azimuth hit table with wraparound window queries.
// ----------------------------------------------------------------------------
// Usage: one request beat enters on the in channel (in_valid/in_stall) and
// gives exactly one result beat on the out channel (out_valid/out_stall).
// The unit works on one request at a time; in_stall is high while busy.
// With no stall a clear result beat leaves in the cycle after its request is
// taken, and a read passes through M_RD_WAIT and M_RD_TAKE first; the unit
// returns to idle before the next request is taken. An insert runs a binary
// search and then shifts the entries above the insertion point one place up,
// each moved entry read and then written through the single-port store. A
// query runs up to four binary searches in turn on the shared search unit.
// The result waits in an output register while out_stall is high; the unit
// takes no new beat until that register is free.
// Reset empties the table (count zero); the store itself is not cleared.
// ----------------------------------------------------------------------------
module phi_window_sorted_range_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          req_type,
    input  logic signed [15:0]                  hit_phi,
    input  logic [15:0]                         hit_id,
    input  logic signed [16:0]                  window_low,
    input  logic signed [16:0]                  window_high,
    input  logic [7:0]                          read_index,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic [8:0]                          first_begin,
    output logic [8:0]                          first_end,
    output logic [8:0]                          second_begin,
    output logic [8:0]                          second_end,
    output logic signed [15:0]                  entry_phi,
    output logic [15:0]                         entry_id,
    output logic [8:0]                          entry_count
);

    localparam int IW = pwsr_pkg::IDX_W;
    localparam int CW = pwsr_pkg::CNT_W;
    localparam int KW = pwsr_pkg::KEY_W;

    typedef enum logic [3:0]
    {
        M_IDLE, M_INS_SRCH, M_INS_RD, M_INS_WR, M_INS_PUT,
        M_RD_WAIT, M_RD_TAKE, M_Q_B1, M_Q_E1, M_Q_B2, M_Q_E2, M_OUT
    } state_t;

    // Store of angles and ids, one port: write or read each cycle.
    logic signed [pwsr_pkg::PHI_W-1:0] angle_mem [pwsr_pkg::MAX_HITS];
    logic [pwsr_pkg::ID_W-1:0]         id_mem    [pwsr_pkg::MAX_HITS];
    logic signed [pwsr_pkg::PHI_W-1:0] rd_phi_reg;
    logic [pwsr_pkg::ID_W-1:0]         rd_id_reg;
    logic [IW-1:0]                     mem_addr;
    logic                              mem_we;
    logic signed [pwsr_pkg::PHI_W-1:0] wr_phi;
    logic [pwsr_pkg::ID_W-1:0]         wr_id;

    state_t                  state_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           ptr_reg;
    logic [CW-1:0]           pos_reg;
    logic signed [pwsr_pkg::PHI_W-1:0] phi_reg;
    logic [pwsr_pkg::ID_W-1:0] id_reg;
    logic signed [KW-1:0]    k1_reg, k2_reg, k3_reg, k4_reg;
    logic                    two_reg;
    logic [7:0]              ridx_reg;
    logic [1:0]              st_reg;
    logic [8:0]              b1_reg, e1_reg, b2_reg, e2_reg;
    logic signed [15:0]      ephi_reg;
    logic [15:0]             eid_reg;

    pwsr_pkg::srch_req_t     sreq;
    pwsr_pkg::srch_rsp_t     srsp;
    logic [IW-1:0]           s_addr;

    logic signed [KW-1:0]    wlo, whi;

    assign wlo = KW'(window_low);
    assign whi = KW'(window_high);

    pwsr_search u_search
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (sreq),
        .count   (count_reg),
        .rd_addr (s_addr),
        .rd_data (rd_phi_reg),
        .rsp     (srsp)
    );

    // Memory port control.
    always_comb
    begin
        mem_we   = 1'b0;
        mem_addr = s_addr;
        wr_phi   = rd_phi_reg;
        wr_id    = rd_id_reg;
        case (state_reg)
            M_INS_RD:  mem_addr = IW'(ptr_reg - 1'b1);
            M_INS_WR:
            begin
                mem_we   = 1'b1;
                mem_addr = ptr_reg[IW-1:0];
            end
            M_INS_PUT:
            begin
                mem_we   = 1'b1;
                mem_addr = pos_reg[IW-1:0];
                wr_phi   = phi_reg;
                wr_id    = id_reg;
            end
            M_RD_WAIT: mem_addr = ridx_reg[IW-1:0];
            default:   mem_addr = s_addr;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            angle_mem[mem_addr] <= wr_phi;
            id_mem[mem_addr]    <= wr_id;
        end
        rd_phi_reg <= angle_mem[mem_addr];
        rd_id_reg  <= id_mem[mem_addr];
    end

    // Search launches: one cycle pulse on entering a search state.
    always_comb
    begin
        sreq.start  = 1'b0;
        sreq.from   = '0;
        sreq.key    = k1_reg;
        sreq.strict = 1'b0;
        if (state_reg == M_IDLE && in_valid && req_type == pwsr_pkg::REQ_INSERT
            && count_reg != CW'(pwsr_pkg::MAX_HITS))
        begin
            sreq.start  = 1'b1;
            sreq.key    = KW'(hit_phi);
            sreq.strict = 1'b1;
        end
        else if (state_reg == M_IDLE && in_valid && req_type == pwsr_pkg::REQ_QUERY)
        begin
            sreq.start = 1'b1;
            sreq.key   = (wlo < whi && wlo < pwsr_pkg::NEG_PI_FX)
                         ? wlo + pwsr_pkg::TWO_PI_FX : wlo;
        end
        else if (srsp.done && state_reg == M_Q_B1)
        begin
            sreq.start  = 1'b1;
            sreq.from   = srsp.result;
            sreq.key    = k2_reg;
            sreq.strict = 1'b1;
        end
        else if (srsp.done && state_reg == M_Q_E1 && two_reg)
        begin
            sreq.start = 1'b1;
            sreq.key   = k3_reg;
        end
        else if (srsp.done && state_reg == M_Q_B2)
        begin
            sreq.start  = 1'b1;
            sreq.from   = srsp.result;
            sreq.key    = k4_reg;
            sreq.strict = 1'b1;
        end
    end

    assign in_stall     = (state_reg != M_IDLE);
    assign out_valid    = (state_reg == M_OUT);
    assign status       = st_reg;
    assign first_begin  = b1_reg;
    assign first_end    = e1_reg;
    assign second_begin = b2_reg;
    assign second_end   = e2_reg;
    assign entry_phi    = ephi_reg;
    assign entry_id     = eid_reg;
    assign entry_count  = 9'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            pos_reg   <= '0;
            phi_reg   <= '0;
            id_reg    <= '0;
            k1_reg    <= '0;
            k2_reg    <= '0;
            k3_reg    <= '0;
            k4_reg    <= '0;
            two_reg   <= 1'b0;
            ridx_reg  <= '0;
            st_reg    <= pwsr_pkg::ST_OK;
            b1_reg    <= '0;
            e1_reg    <= '0;
            b2_reg    <= '0;
            e2_reg    <= '0;
            ephi_reg  <= '0;
            eid_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                M_IDLE:
                begin
                    if (in_valid)
                    begin
                        st_reg   <= pwsr_pkg::ST_OK;
                        b1_reg   <= '0;
                        e1_reg   <= '0;
                        b2_reg   <= '0;
                        e2_reg   <= '0;
                        ephi_reg <= '0;
                        eid_reg  <= '0;
                        phi_reg  <= hit_phi;
                        id_reg   <= hit_id;
                        ridx_reg <= read_index;
                        case (pwsr_pkg::req_t'(req_type))
                            pwsr_pkg::REQ_CLEAR:
                            begin
                                count_reg <= '0;
                                state_reg <= M_OUT;
                            end
                            pwsr_pkg::REQ_INSERT:
                            begin
                                if (count_reg == CW'(pwsr_pkg::MAX_HITS))
                                begin
                                    st_reg    <= pwsr_pkg::ST_FULL;
                                    state_reg <= M_OUT;
                                end
                                else
                                begin
                                    state_reg <= M_INS_SRCH;
                                end
                            end
                            pwsr_pkg::REQ_QUERY:
                            begin
                                if (wlo < whi && wlo < pwsr_pkg::NEG_PI_FX)
                                begin
                                    k2_reg  <= pwsr_pkg::PI_FX;
                                    k4_reg  <= whi;
                                    two_reg <= 1'b1;
                                end
                                else if (wlo < whi && whi > pwsr_pkg::PI_FX)
                                begin
                                    k2_reg  <= pwsr_pkg::PI_FX;
                                    k4_reg  <= whi - pwsr_pkg::TWO_PI_FX;
                                    two_reg <= 1'b1;
                                end
                                else if (wlo < whi)
                                begin
                                    k2_reg  <= whi;
                                    k4_reg  <= whi;
                                    two_reg <= 1'b0;
                                end
                                else
                                begin
                                    k2_reg  <= pwsr_pkg::PI_FX;
                                    k4_reg  <= whi;
                                    two_reg <= 1'b1;
                                end
                                k1_reg    <= wlo;
                                k3_reg    <= pwsr_pkg::NEG_PI_FX;
                                state_reg <= M_Q_B1;
                            end
                            pwsr_pkg::REQ_READ:
                            begin
                                if (CW'(read_index) >= count_reg)
                                begin
                                    st_reg    <= pwsr_pkg::ST_BAD_IDX;
                                    state_reg <= M_OUT;
                                end
                                else
                                begin
                                    state_reg <= M_RD_WAIT;
                                end
                            end
                            default: state_reg <= M_OUT;
                        endcase
                    end
                end
                M_INS_SRCH:
                begin
                    if (srsp.done)
                    begin
                        pos_reg   <= srsp.result;
                        ptr_reg   <= count_reg;
                        state_reg <= (count_reg > srsp.result) ? M_INS_RD : M_INS_PUT;
                    end
                end
                M_INS_RD:  state_reg <= M_INS_WR;
                M_INS_WR:
                begin
                    ptr_reg   <= ptr_reg - 1'b1;
                    state_reg <= (ptr_reg - 1'b1 > pos_reg) ? M_INS_RD : M_INS_PUT;
                end
                M_INS_PUT:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= M_OUT;
                end
                M_RD_WAIT: state_reg <= M_RD_TAKE;
                M_RD_TAKE:
                begin
                    ephi_reg  <= rd_phi_reg;
                    eid_reg   <= rd_id_reg;
                    state_reg <= M_OUT;
                end
                M_Q_B1:
                begin
                    if (srsp.done)
                    begin
                        b1_reg    <= 9'(srsp.result);
                        state_reg <= M_Q_E1;
                    end
                end
                M_Q_E1:
                begin
                    if (srsp.done)
                    begin
                        e1_reg    <= 9'(srsp.result);
                        state_reg <= two_reg ? M_Q_B2 : M_OUT;
                    end
                end
                M_Q_B2:
                begin
                    if (srsp.done)
                    begin
                        b2_reg    <= 9'(srsp.result);
                        state_reg <= M_Q_E2;
                    end
                end
                M_Q_E2:
                begin
                    if (srsp.done)
                    begin
                        e2_reg    <= 9'(srsp.result);
                        state_reg <= M_OUT;
                    end
                end
                M_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= M_IDLE;
                    end
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(pwsr_pkg::MAX_HITS))
        else $error("count beyond capacity");
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (first_begin <= first_end && second_begin <= second_end))
        else $error("range end below begin");
    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == M_INS_WR |-> ptr_reg > pos_reg)
        else $error("shift below insertion point");
    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == M_INS_PUT |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow table");

endmodule
